// ===== sv/chkv_pkg.sv =====
// Shared types, sizes and codes of the chained hash key-value table.
package chkv_pkg;

  localparam int unsigned NumBuckets  = 256;
  localparam int unsigned PoolEntries = 256;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned ValW        = 64;
  localparam int unsigned CmdW        = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountW      = 9;
  localparam int unsigned BucketW     = $clog2(NumBuckets);
  localparam int unsigned NodeW       = $clog2(PoolEntries);
  localparam int unsigned LinkW       = $clog2(PoolEntries + 1);
  localparam int unsigned HashModulus = 10000000;
  localparam int unsigned RemW        = $clog2(HashModulus);
  localparam int unsigned DigitW      = 4;
  localparam int unsigned NumDigits   = KeyW / DigitW;

  localparam logic [CmdW-1:0] CmdSet = 2'd0;
  localparam logic [CmdW-1:0] CmdGet = 2'd1;
  localparam logic [CmdW-1:0] CmdDel = 2'd2;
  localparam logic [CmdW-1:0] CmdNop = 2'd3;

  localparam logic [StatusW-1:0] StFound    = 2'd0;
  localparam logic [StatusW-1:0] StInserted = 2'd1;
  localparam logic [StatusW-1:0] StAbsent   = 2'd2;
  localparam logic [StatusW-1:0] StFull     = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]        cmd;
    logic signed [KeyW-1:0] key;
    logic [ValW-1:0]        value_in;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValW-1:0]    value_out;
    logic [CountW-1:0]  entry_count;
  } res_t;

  typedef struct packed {
    logic            valid;
    logic [RemW-1:0] rem;
  } rem_cell_t;

  typedef struct packed {
    logic               valid;
    logic [BucketW-1:0] bucket;
  } hash_res_t;

endpackage

// ===== sv/chkv_rem_cell.sv =====
// One cell of the remainder chain: folds one key digit into the running remainder.
module chkv_rem_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  chkv_pkg::rem_cell_t   cell_i,
  input  logic [chkv_pkg::DigitW-1:0] digit_i,
  output chkv_pkg::rem_cell_t   cell_o
);

  localparam int unsigned XW = chkv_pkg::RemW + chkv_pkg::DigitW;

  logic [XW-1:0]             x;
  logic [XW-1:0]             sel;
  logic                      valid_q;
  logic [chkv_pkg::RemW-1:0] rem_q;

  // The incoming remainder is below the modulus, so the quotient digit fits in DigitW bits.
  // The largest multiple that still fits is subtracted.
  always_comb begin
    x   = {cell_i.rem, digit_i};
    sel = x;
    for (int k = 1; k < (1 << chkv_pkg::DigitW); k++) begin
      if (x >= XW'(k * chkv_pkg::HashModulus)) begin
        sel = x - XW'(k * chkv_pkg::HashModulus);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= sel[chkv_pkg::RemW-1:0];
  end

  assign cell_o = '{valid: valid_q, rem: rem_q};

endmodule

// ===== sv/chkv_hash.sv =====
// Bucket hash: signed key remainder through a row of digit cells, then the low bits.
module chkv_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [chkv_pkg::KeyW-1:0] key_i,
  output chkv_pkg::hash_res_t          hash_o
);

  logic [chkv_pkg::KeyW-1:0]    mag_q;
  logic                         neg_q;
  logic                         launch_q;
  chkv_pkg::rem_cell_t          chain [chkv_pkg::NumDigits+1];
  logic [chkv_pkg::BucketW-1:0] rem_low;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= start_i;
    end
  end

  // Magnitude and sign stay put while the remainder travels down the chain.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= key_i[chkv_pkg::KeyW-1];
      mag_q <= key_i[chkv_pkg::KeyW-1] ? (~$unsigned(key_i) + chkv_pkg::KeyW'(1))
                                       : $unsigned(key_i);
    end
  end

  assign chain[0] = '{valid: launch_q, rem: '0};

  for (genvar i = 0; i < chkv_pkg::NumDigits; i++) begin : g_cell
    chkv_rem_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cell_i  (chain[i]),
      .digit_i (mag_q[(chkv_pkg::NumDigits-1-i)*chkv_pkg::DigitW +: chkv_pkg::DigitW]),
      .cell_o  (chain[i+1])
    );
  end

  // A negative key has a negative remainder; its low bits are those of the negated value.
  assign rem_low = chain[chkv_pkg::NumDigits].rem[chkv_pkg::BucketW-1:0];
  assign hash_o.valid  = chain[chkv_pkg::NumDigits].valid;
  assign hash_o.bucket = neg_q ? (chkv_pkg::BucketW'(0) - rem_low) : rem_low;

endmodule

// ===== sv/chkv_table.sv =====
// Chain walker: bucket heads, node pool, free stack and the operation sequencer.
module chkv_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  chkv_pkg::req_t      req_i,
  output logic                hash_start_o,
  input  chkv_pkg::hash_res_t hash_i,
  output logic                busy_o,
  output logic                res_strobe_o,
  output chkv_pkg::res_t      res_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StHash  = 6'b000010,
    StHead  = 6'b000100,
    StNode  = 6'b001000,
    StAlloc = 6'b010000,
    StLink  = 6'b100000
  } state_e;

  localparam int unsigned LinkW = chkv_pkg::LinkW;
  localparam int unsigned NodeW = chkv_pkg::NodeW;

  state_e state_q, state_d;
  chkv_pkg::req_t req_q, req_d;
  logic [chkv_pkg::BucketW-1:0] bucket_q, bucket_d;
  logic [LinkW-1:0] cur_q, cur_d, prev_q, prev_d, tail_q, tail_d;
  logic [NodeW-1:0] alloc_q, alloc_d;
  logic [chkv_pkg::CountW-1:0] pair_count_q, pair_count_d;
  logic [chkv_pkg::CountW-1:0] fresh_q, fresh_d, sp_q, sp_d;
  chkv_pkg::res_t res_q, res_d;
  logic res_strobe_q, res_strobe_d;

  // Storage.
  logic [LinkW-1:0]         head_mem  [chkv_pkg::NumBuckets];
  logic [chkv_pkg::NumBuckets-1:0] head_vld_q;
  logic [chkv_pkg::KeyW-1:0] key_mem  [chkv_pkg::PoolEntries];
  logic [chkv_pkg::ValW-1:0] val_mem  [chkv_pkg::PoolEntries];
  logic [LinkW-1:0]         link_mem  [chkv_pkg::PoolEntries];
  logic [NodeW-1:0]         stack_mem [chkv_pkg::PoolEntries];

  logic [LinkW-1:0]          head_rd_q;
  logic                      head_vld_rd_q;
  logic [chkv_pkg::KeyW-1:0] key_rd_q;
  logic [chkv_pkg::ValW-1:0] val_rd_q;
  logic [LinkW-1:0]          link_rd_q;
  logic [NodeW-1:0]          stack_rd_q;

  logic                      head_we;
  logic [LinkW-1:0]          head_wdata;
  logic                      key_we, val_we, link_we, stack_we;
  logic [NodeW-1:0]          val_waddr, link_waddr;
  logic [LinkW-1:0]          link_wdata;
  logic [NodeW-1:0]          node_raddr, stack_raddr, cur_node, alloc_node;
  logic [LinkW-1:0]          head_link;

  logic                      hit, miss, fin;
  logic [chkv_pkg::StatusW-1:0] fin_status;
  logic [chkv_pkg::ValW-1:0] fin_value;

  assign head_link   = head_vld_rd_q ? head_rd_q : '0;
  assign cur_node    = NodeW'(cur_q - LinkW'(1));
  assign stack_raddr = NodeW'(sp_q - chkv_pkg::CountW'(1));
  // Freed nodes are reused first; otherwise the next never-used node is taken.
  assign alloc_node  = (sp_q != '0) ? stack_rd_q : fresh_q[NodeW-1:0];

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    bucket_d     = bucket_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    tail_d       = tail_q;
    alloc_d      = alloc_q;
    pair_count_d = pair_count_q;
    fresh_d      = fresh_q;
    sp_d         = sp_q;
    res_d        = res_q;
    res_strobe_d = 1'b0;
    hash_start_o = 1'b0;
    head_we      = 1'b0;
    head_wdata   = '0;
    key_we       = 1'b0;
    val_we       = 1'b0;
    val_waddr    = '0;
    link_we      = 1'b0;
    link_waddr   = '0;
    link_wdata   = '0;
    stack_we     = 1'b0;
    node_raddr   = '0;
    hit          = 1'b0;
    miss         = 1'b0;
    fin          = 1'b0;
    fin_status   = chkv_pkg::StAbsent;
    fin_value    = '0;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          req_d = req_i;
          if (req_i.cmd == chkv_pkg::CmdNop) begin
            fin = 1'b1;
          end else begin
            hash_start_o = 1'b1;
            state_d      = StHash;
          end
        end
      end
      StHash: begin
        if (hash_i.valid) begin
          bucket_d = hash_i.bucket;
          state_d  = StHead;
        end
      end
      StHead: begin
        prev_d = '0;
        tail_d = '0;
        if (head_link == '0) begin
          miss = 1'b1;
        end else begin
          cur_d      = head_link;
          node_raddr = NodeW'(head_link - LinkW'(1));
          state_d    = StNode;
        end
      end
      StNode: begin
        if (key_rd_q == req_q.key) begin
          hit = 1'b1;
        end else if (link_rd_q == '0) begin
          miss   = 1'b1;
          tail_d = cur_q;
        end else begin
          prev_d     = cur_q;
          cur_d      = link_rd_q;
          node_raddr = NodeW'(link_rd_q - LinkW'(1));
        end
      end
      StAlloc: begin
        alloc_d      = alloc_node;
        key_we       = 1'b1;
        val_we       = 1'b1;
        val_waddr    = alloc_node;
        link_we      = 1'b1;
        link_waddr   = alloc_node;
        link_wdata   = '0;
        pair_count_d = pair_count_q + chkv_pkg::CountW'(1);
        if (sp_q != '0) begin
          sp_d = sp_q - chkv_pkg::CountW'(1);
        end else begin
          fresh_d = fresh_q + chkv_pkg::CountW'(1);
        end
        if (tail_q == '0) begin
          head_we    = 1'b1;
          head_wdata = LinkW'(alloc_node) + LinkW'(1);
          fin        = 1'b1;
          fin_status = chkv_pkg::StInserted;
        end else begin
          state_d = StLink;
        end
      end
      StLink: begin
        link_we    = 1'b1;
        link_waddr = NodeW'(tail_q - LinkW'(1));
        link_wdata = LinkW'(alloc_q) + LinkW'(1);
        fin        = 1'b1;
        fin_status = chkv_pkg::StInserted;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (hit) begin
      fin        = 1'b1;
      fin_status = chkv_pkg::StFound;
      case (req_q.cmd)
        chkv_pkg::CmdSet: begin
          val_we    = 1'b1;
          val_waddr = cur_node;
        end
        chkv_pkg::CmdGet: begin
          fin_value = val_rd_q;
        end
        chkv_pkg::CmdDel: begin
          fin_value = val_rd_q;
          // Unlink: the predecessor, or the bucket head, takes over the successor.
          if (prev_q == '0) begin
            head_we    = 1'b1;
            head_wdata = link_rd_q;
          end else begin
            link_we    = 1'b1;
            link_waddr = NodeW'(prev_q - LinkW'(1));
            link_wdata = link_rd_q;
          end
          stack_we = 1'b1;
          sp_d     = sp_q + chkv_pkg::CountW'(1);
          if (pair_count_q != '0) begin
            pair_count_d = pair_count_q - chkv_pkg::CountW'(1);
          end
        end
        default: ;
      endcase
    end

    if (miss) begin
      if (req_q.cmd == chkv_pkg::CmdSet) begin
        if (pair_count_q >= chkv_pkg::CountW'(chkv_pkg::PoolEntries)) begin
          fin        = 1'b1;
          fin_status = chkv_pkg::StFull;
        end else begin
          state_d = StAlloc;
        end
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      state_d      = StIdle;
      res_strobe_d = 1'b1;
      res_d        = '{status: fin_status, value_out: fin_value, entry_count: pair_count_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      pair_count_q <= '0;
      fresh_q      <= '0;
      sp_q         <= '0;
      res_strobe_q <= 1'b0;
      head_vld_q   <= '0;
    end else begin
      state_q      <= state_d;
      pair_count_q <= pair_count_d;
      fresh_q      <= fresh_d;
      sp_q         <= sp_d;
      res_strobe_q <= res_strobe_d;
      if (head_we) begin
        head_vld_q[bucket_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    bucket_q <= bucket_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    tail_q   <= tail_d;
    alloc_q  <= alloc_d;
    res_q    <= res_d;
  end

  // Bucket heads; a head whose valid bit is clear reads as the null link.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[bucket_q] <= head_wdata;
    end
    head_rd_q     <= head_mem[hash_i.bucket];
    head_vld_rd_q <= head_vld_q[hash_i.bucket];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[alloc_node] <= req_q.key;
    end
    key_rd_q <= key_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= req_q.value_in;
    end
    val_rd_q <= val_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[sp_q[NodeW-1:0]] <= cur_node;
    end
    stack_rd_q <= stack_mem[stack_raddr];
  end

  assign busy_o       = (state_q != StIdle);
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

// ===== sv/chained_hash_key_value_table_unit.sv =====
// Top level of the chained hash key-value table.
//
//   channel  | ports                | transaction
//   ---------+----------------------+------------------------------------------
//   request  | start, busy, req_i   | taken at a clock edge with start high, busy low
//   result   | res_strobe_o, res_o  | shown for one cycle, taken at the edge ending it
//
// One operation at a time. A set, get or delete passes through the 16-cell remainder
// chain of the bucket hash, then reads the bucket head and visits chain nodes one by one.
// An insert adds an allocate step, and a link step when it appends behind an existing node.
// Unused command code 3 answers in the next cycle. Reset clears the bucket head
// valid bits and the counters at once, with no clearing pass. Results cannot be held off.
module chained_hash_key_value_table_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  chkv_pkg::req_t req_i,
  output logic           res_strobe_o,
  output chkv_pkg::res_t res_o
);

  logic                hash_start;
  chkv_pkg::hash_res_t hash_res;

  chkv_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (req_i.key),
    .hash_o  (hash_res)
  );

  chkv_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .req_i        (req_i),
    .hash_start_o (hash_start),
    .hash_i       (hash_res),
    .busy_o       (busy),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

// ===== sv/chkv_checker.sv =====
// Port-level checks of the table unit, bound to its top level.
module chkv_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input chkv_pkg::req_t req_i,
  input logic           res_strobe_o,
  input chkv_pkg::res_t res_o
);

  // A real operation keeps the unit busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.cmd != chkv_pkg::CmdNop)) |=> busy)
    else $error("busy not raised after an accepted operation");

  // The unused command code answers in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.cmd == chkv_pkg::CmdNop)) |=> res_strobe_o)
    else $error("no result after an unused command code");

  // Full is only reported when every pool node holds a pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && (res_o.status == chkv_pkg::StFull))
      |-> (res_o.entry_count == chkv_pkg::CountW'(chkv_pkg::PoolEntries)))
    else $error("table full reported below capacity");

  // Only a found key with a get or a delete carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && (res_o.status != chkv_pkg::StFound)) |-> (res_o.value_out == '0))
    else $error("value returned without a found key");

endmodule

bind chained_hash_key_value_table_unit chkv_checker u_chkv_checker (.*);
